FILE: hw/rtl/set_assoc_lru_cache_tracker_assert.svh
// Assertion macros shared by the cache tracker RTL.
`ifndef SET_ASSOC_LRU_CACHE_TRACKER_ASSERT_SVH
`define SET_ASSOC_LRU_CACHE_TRACKER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SALRU_ASSERT_IMP(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("salru assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SALRU_ASSERT_NXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("salru assertion failed");

`endif

FILE: hw/rtl/salru_pkg.sv
// Shared widths, constants and helpers of the cache tracker.
`default_nettype none

package salru_pkg;

  localparam int unsigned LINE_W      = 32;
  localparam int unsigned CNT_W       = 32;
  localparam int unsigned SHIFT_W     = 3;
  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 3'd2;
  localparam logic [CNT_W-1:0]   CNT_MAX     = 32'hFFFF_FFFF;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + CNT_W'(1);
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/salru_lru_update.sv
// Tag compare and true-LRU reorder of one set.
`default_nettype none

module salru_lru_update #(
  parameter int unsigned WAYS  = 4,
  parameter int unsigned TAG_W = 26
) (
  input  wire logic [WAYS-1:0]            valid_i,
  input  wire logic [WAYS-1:0][TAG_W-1:0] tags_i,
  input  wire logic [TAG_W-1:0]           tag_i,
  output logic                            hit_o,
  output logic [WAYS-1:0]                 valid_o,
  output logic [WAYS-1:0][TAG_W-1:0]      tags_o
);

  localparam int unsigned WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

  always_comb begin
    logic [WAY_W-1:0] idx;
    logic             found;
    found = 1'b0;
    idx   = '0;
    // first matching way wins
    for (int w = 0; w < WAYS; w++) begin
      if (!found && valid_i[w] && (tags_i[w] == tag_i)) begin
        found = 1'b1;
        idx   = WAY_W'(w);
      end
    end
    hit_o      = found;
    valid_o    = valid_i;
    tags_o     = tags_i;
    valid_o[0] = 1'b1;
    tags_o[0]  = tag_i;
    // ways in front of the hit, or all on a miss, move back by one
    for (int w = 1; w < WAYS; w++) begin
      if (!found || (WAY_W'(w) <= idx)) begin
        valid_o[w] = valid_i[w-1];
        tags_o[w]  = tags_i[w-1];
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/set_assoc_lru_cache_tracker.sv
// Set-associative true-LRU cache tag tracker, top level.
//
//  channel   dir  ready/valid              payload
//  s_axis    in   s_axis_tvalid/tready     tdata: word_addr, tuser: access_kind
//  m_axis    out  m_axis_tvalid/tready     tdata: miss_line, counters, tuser: hit
//  cfg       in   cfg_we_i (no wait)       cfg_wdata_i: word_shift
//
// One transfer per cycle sustained while m_axis_tready stays high and no clearing pass runs; the
// set row is read into a register at the input transfer edge, then compared, updated and
// captured in the result register when the update stage advances.
// A row written to the same set at the input transfer edge is forwarded around the memory.
// After reset the set memory is cleared one row a cycle, through all SETS rows, with
// s_axis_tready low; configuration writes are taken throughout.
// A stalled result holds the update stage; s_axis_tready drops with it.
`default_nettype none

module set_assoc_lru_cache_tracker #(
  parameter int unsigned SETS = 64,
  parameter int unsigned WAYS = 4
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [salru_pkg::SHIFT_W-1:0] cfg_wdata_i,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [31:0]                  s_axis_tdata,   // [31:0] word_addr
  input  wire logic                         s_axis_tuser,   // [0] access_kind
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  // [31:0] miss_line, [63:32] hit_total, [95:64] miss_total,
  // [127:96] miss_kind0_total, [159:128] miss_kind1_total
  output logic [159:0]                      m_axis_tdata,
  output logic                              m_axis_tuser    // [0] hit
);

  `include "set_assoc_lru_cache_tracker_assert.svh"

  localparam int unsigned LINE_W   = salru_pkg::LINE_W;
  localparam int unsigned CNT_W    = salru_pkg::CNT_W;
  localparam int unsigned SET_BITS = $clog2(SETS);
  localparam int unsigned IDX_W    = (SET_BITS > 0) ? SET_BITS : 1;
  localparam int unsigned TAG_W    = LINE_W - SET_BITS;
  localparam int unsigned ROW_W    = WAYS * (TAG_W + 1);

  // configuration
  logic [salru_pkg::SHIFT_W-1:0] word_shift_q;

  // clearing pass
  logic             clearing_q;
  logic [IDX_W-1:0] clr_idx_q;

  // set memory, row = {tags, valids}
  logic [ROW_W-1:0] set_mem_q [SETS];
  logic [ROW_W-1:0] rd_row_q;
  logic [ROW_W-1:0] fwd_row_q;
  logic             fwd_sel_q;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [ROW_W-1:0] mem_wdata;

  // input stage
  logic              s_fire;
  logic [LINE_W-1:0] in_line;
  logic [IDX_W-1:0]  in_set;
  logic              s1_valid_q;
  logic [LINE_W-1:0] s1_line_q;
  logic [IDX_W-1:0]  s1_set_q;
  logic              s1_kind_q;
  logic              s1_adv;

  // update stage
  logic [ROW_W-1:0]            cur_row;
  logic [WAYS-1:0]             cur_valid;
  logic [WAYS-1:0][TAG_W-1:0]  cur_tags;
  logic [TAG_W-1:0]            s1_tag;
  logic                        upd_hit;
  logic [WAYS-1:0]             upd_valid;
  logic [WAYS-1:0][TAG_W-1:0]  upd_tags;
  logic [ROW_W-1:0]            upd_row;

  // result register and counters
  logic              out_valid_q;
  logic              out_hit_q;
  logic [LINE_W-1:0] out_miss_line_q;
  logic [CNT_W-1:0]  hit_cnt_q;
  logic [CNT_W-1:0]  miss_cnt_q;
  logic [CNT_W-1:0]  kind0_cnt_q;
  logic [CNT_W-1:0]  kind1_cnt_q;

  assign in_line = s_axis_tdata >> word_shift_q;
  assign in_set  = (SET_BITS > 0) ? IDX_W'(in_line) : '0;

  assign s1_adv        = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !clearing_q && (!s1_valid_q || s1_adv);
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  assign cur_row   = fwd_sel_q ? fwd_row_q : rd_row_q;
  assign cur_valid = cur_row[WAYS-1:0];
  assign cur_tags  = cur_row[ROW_W-1:WAYS];
  assign s1_tag    = TAG_W'(s1_line_q >> SET_BITS);

  salru_lru_update #(
    .WAYS  (WAYS),
    .TAG_W (TAG_W)
  ) u_lru_update (
    .valid_i (cur_valid),
    .tags_i  (cur_tags),
    .tag_i   (s1_tag),
    .hit_o   (upd_hit),
    .valid_o (upd_valid),
    .tags_o  (upd_tags)
  );

  assign upd_row = {upd_tags, upd_valid};

  assign mem_we    = clearing_q || s1_adv;
  assign mem_waddr = clearing_q ? clr_idx_q : s1_set_q;
  assign mem_wdata = clearing_q ? '0 : upd_row;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      set_mem_q[mem_waddr] <= mem_wdata;
    end
    if (s_fire) begin
      rd_row_q  <= set_mem_q[in_set];
      fwd_row_q <= upd_row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_shift_q <= salru_pkg::SHIFT_RESET;
      clearing_q   <= 1'b1;
      clr_idx_q    <= '0;
      fwd_sel_q    <= 1'b0;
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      hit_cnt_q    <= '0;
      miss_cnt_q   <= '0;
      kind0_cnt_q  <= '0;
      kind1_cnt_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        word_shift_q <= cfg_wdata_i;
      end
      if (clearing_q) begin
        clr_idx_q <= clr_idx_q + IDX_W'(1);
        if (clr_idx_q == IDX_W'(SETS - 1)) begin
          clearing_q <= 1'b0;
        end
      end
      if (s_fire) begin
        // forward the row being written now when the new access hits the same set
        fwd_sel_q <= s1_adv && (s1_set_q == in_set);
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
        if (upd_hit) begin
          hit_cnt_q <= salru_pkg::sat_inc(hit_cnt_q);
        end else begin
          miss_cnt_q <= salru_pkg::sat_inc(miss_cnt_q);
          if (s1_kind_q) begin
            kind1_cnt_q <= salru_pkg::sat_inc(kind1_cnt_q);
          end else begin
            kind0_cnt_q <= salru_pkg::sat_inc(kind0_cnt_q);
          end
        end
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      s1_line_q <= in_line;
      s1_set_q  <= in_set;
      s1_kind_q <= s_axis_tuser;
    end
    if (s1_adv) begin
      out_hit_q       <= upd_hit;
      out_miss_line_q <= upd_hit ? '0 : s1_line_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_hit_q;
  assign m_axis_tdata  = {kind1_cnt_q, kind0_cnt_q, miss_cnt_q, hit_cnt_q, out_miss_line_q};

  `SALRU_ASSERT_IMP(a_no_accept_in_clear, clk_i, rst_ni, clearing_q, !s_fire)
  `SALRU_ASSERT_IMP(a_hit_no_miss_line, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser,
                    out_miss_line_q == '0)
  `SALRU_ASSERT_IMP(a_miss_sum, clk_i, rst_ni,
                    m_axis_tvalid && (miss_cnt_q != salru_pkg::CNT_MAX),
                    {1'b0, miss_cnt_q} == ({1'b0, kind0_cnt_q} + {1'b0, kind1_cnt_q}))
  `SALRU_ASSERT_NXT(a_adv_gives_result, clk_i, rst_ni, s1_adv, m_axis_tvalid)

endmodule

`default_nettype wire

FILE: test/tb_top.sv
// Testbench for the set-associative true-LRU cache tracker: predicts every lookup and checks it.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SETS = 64;
  localparam int unsigned WAYS = 4;
  localparam int unsigned TAG_BITS = salru_pkg::LINE_W - $clog2(SETS);
  localparam int unsigned PHASE_ITEMS = 66;

  typedef struct {
    logic [31:0] addr;
    logic        kind;
  } access_t;

  typedef struct {
    logic                         hit;
    logic [salru_pkg::LINE_W-1:0] miss_line;
    logic [salru_pkg::CNT_W-1:0]  hits;
    logic [salru_pkg::CNT_W-1:0]  misses;
    logic [salru_pkg::CNT_W-1:0]  kind0_misses;
    logic [salru_pkg::CNT_W-1:0]  kind1_misses;
  } outcome_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [salru_pkg::SHIFT_W-1:0] cfg_wdata_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [159:0] m_axis_tdata;
  logic m_axis_tuser;

  // Shadow copy of the tag store, recency order with way 0 the newest.
  logic                          way_valid [SETS][WAYS];
  logic [31:0]                   way_tag [SETS][WAYS];
  logic [salru_pkg::CNT_W-1:0]   hit_count;
  logic [salru_pkg::CNT_W-1:0]   miss_count;
  logic [salru_pkg::CNT_W-1:0]   kind_misses [2];
  logic [salru_pkg::SHIFT_W-1:0] model_shift = salru_pkg::SHIFT_RESET;

  access_t  access_queue [$];
  outcome_t lookup_outcomes [$];
  int n_pushed = 0;
  int n_accepted = 0;
  int n_checked = 0;
  int n_errors = 0;
  int send_gap = 0;
  int take_gap = 0;
  logic in_taken = 1'b0;
  logic out_taken = 1'b0;

  set_assoc_lru_cache_tracker #(
    .SETS(SETS),
    .WAYS(WAYS)
  ) uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  always #2 clk_i = ~clk_i;

  // Look up one access in the shadow store and apply the LRU update.
  function automatic outcome_t lookup_and_touch(input logic [31:0] addr, input logic kind);
    logic [31:0] line;
    logic [31:0] set_idx;
    logic [31:0] tag;
    int found;
    outcome_t o;
    line = addr >> model_shift;
    set_idx = line % SETS;
    tag = line / SETS;
    found = -1;
    for (int w = 0; w < WAYS; w++)
      if (found < 0 && way_valid[set_idx][w] && way_tag[set_idx][w] == tag) found = w;
    o.miss_line = '0;
    if (found >= 0) begin
      for (int w = found; w >= 1; w--) begin
        way_valid[set_idx][w] = way_valid[set_idx][w-1];
        way_tag[set_idx][w] = way_tag[set_idx][w-1];
      end
      if (hit_count != salru_pkg::CNT_MAX) hit_count++;
    end else begin
      for (int w = WAYS - 1; w >= 1; w--) begin
        way_valid[set_idx][w] = way_valid[set_idx][w-1];
        way_tag[set_idx][w] = way_tag[set_idx][w-1];
      end
      o.miss_line = line;
      if (miss_count != salru_pkg::CNT_MAX) miss_count++;
      if (kind_misses[kind] != salru_pkg::CNT_MAX) kind_misses[kind]++;
    end
    way_valid[set_idx][0] = 1'b1;
    way_tag[set_idx][0] = tag;
    o.hit = (found >= 0);
    o.hits = hit_count;
    o.misses = miss_count;
    o.kind0_misses = kind_misses[0];
    o.kind1_misses = kind_misses[1];
    return o;
  endfunction

  // Build a word address from tag, set and word offset at the current line size.
  function automatic logic [31:0] compose_addr(input logic [31:0] tag, input logic [31:0] set_idx,
                                               input logic [31:0] off);
    logic [31:0] off_mask;
    off_mask = (32'd1 << model_shift) - 32'd1;
    return (((tag * SETS) + set_idx) << model_shift) | (off & off_mask);
  endfunction

  // Idle some cycles per item, with regular stretches of none.
  function automatic int draw_gap(input int n);
    return (n % 48 < 12) ? 0 : $urandom_range(0, 7);
  endfunction

  task automatic flag_mismatch(input string field, input logic [31:0] got,
                               input logic [31:0] want);
    $display("mismatch at result %0d: %s got %h expected %h", n_checked, field, got, want);
    n_errors++;
  endtask

  task automatic push_access(input logic [31:0] addr, input logic kind);
    access_t a;
    a.addr = addr;
    a.kind = kind;
    access_queue.push_back(a);
    n_pushed++;
  endtask

  task automatic set_line_shift(input logic [salru_pkg::SHIFT_W-1:0] v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    model_shift = v;
  endtask

  task automatic drain();
    while (!(n_accepted == n_pushed && lookup_outcomes.size() == 0)) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  // Input driver: hold each word until its transfer, then wait out the drawn gap.
  always @(negedge clk_i) begin
    logic next_valid;
    access_t a;
    if (rst_ni) begin
      next_valid = s_axis_tvalid;
      if (s_axis_tvalid && in_taken) begin
        next_valid = 1'b0;
        send_gap = draw_gap(n_accepted + 20);
      end
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (access_queue.size() > 0) begin
          a = access_queue.pop_front();
          s_axis_tdata <= a.addr;
          s_axis_tuser <= a.kind;
          next_valid = 1'b1;
        end
      end
      s_axis_tvalid <= next_valid;
    end
  end

  // Result sink: stall for a drawn number of cycles after each transfer.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_taken) take_gap = draw_gap(n_checked + 31);
      if (take_gap > 0) begin
        take_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Monitor: predict on every input transfer, check on every output transfer.
  always @(posedge clk_i) begin
    outcome_t want;
    if (!rst_ni) begin
      in_taken <= 1'b0;
      out_taken <= 1'b0;
    end else begin
      in_taken <= s_axis_tvalid && s_axis_tready;
      out_taken <= m_axis_tvalid && m_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        lookup_outcomes.push_back(lookup_and_touch(s_axis_tdata, s_axis_tuser));
        n_accepted++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        n_checked++;
        if (lookup_outcomes.size() == 0) begin
          flag_mismatch("result with no lookup pending", m_axis_tdata[31:0], '0);
        end else begin
          want = lookup_outcomes.pop_front();
          if (m_axis_tuser !== want.hit)
            flag_mismatch("hit", 32'(m_axis_tuser), 32'(want.hit));
          if (m_axis_tdata[31:0] !== want.miss_line)
            flag_mismatch("miss_line", m_axis_tdata[31:0], want.miss_line);
          if (m_axis_tdata[63:32] !== want.hits)
            flag_mismatch("hit_total", m_axis_tdata[63:32], want.hits);
          if (m_axis_tdata[95:64] !== want.misses)
            flag_mismatch("miss_total", m_axis_tdata[95:64], want.misses);
          if (m_axis_tdata[127:96] !== want.kind0_misses)
            flag_mismatch("miss_kind0_total", m_axis_tdata[127:96], want.kind0_misses);
          if (m_axis_tdata[159:128] !== want.kind1_misses)
            flag_mismatch("miss_kind1_total", m_axis_tdata[159:128], want.kind1_misses);
        end
      end
    end
  end

  initial begin
    logic [31:0] tag_pool [6];
    logic [salru_pkg::SHIFT_W-1:0] shifts [6];
    int r;
    shifts = '{salru_pkg::SHIFT_RESET, 3'd0, 3'd7, 3'd6, 3'd1, 3'd2};
    shifts[4] = $urandom_range(0, 7);
    for (int s = 0; s < SETS; s++)
      for (int w = 0; w < WAYS; w++) begin
        way_valid[s][w] = 1'b0;
        way_tag[s][w] = '0;
      end
    hit_count = '0;
    miss_count = '0;
    kind_misses[0] = '0;
    kind_misses[1] = '0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: address extremes, same-line hit, fill and evict one set, LRU reorder.
    push_access(32'h0000_0000, 1'b0);
    push_access(32'h0000_0003, 1'b1);
    push_access(32'hFFFF_FFFF, 1'b1);
    push_access(32'hFFFF_FFFC, 1'b0);
    for (int t = 1; t <= 5; t++) push_access(compose_addr(t, 5, t), t[0]);
    push_access(compose_addr(1, 5, 0), 1'b1);
    push_access(compose_addr(3, 5, 3), 1'b0);
    push_access(compose_addr(3, 5, 1), 1'b1);
    push_access(compose_addr(5, 5, 0), 1'b0);
    push_access(compose_addr(2, 5, 2), 1'b1);
    push_access(32'h8000_0000, 1'b0);
    push_access(32'h7FFF_FFFF, 1'b1);

    for (int p = 0; p < 6; p++) begin
      if (p > 0) begin
        drain();
        set_line_shift(shifts[p]);
      end
      // Small tags plus a few wide ones, mostly confined to a handful of sets to force reuse.
      for (int i = 0; i < 6; i++)
        tag_pool[i] = (i < 3) ? i : ($urandom & ((32'd1 << (TAG_BITS - model_shift)) - 32'd1));
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        r = $urandom_range(0, 9);
        if (r == 0)
          push_access($urandom, 1'($urandom_range(0, 1)));
        else
          push_access(compose_addr(tag_pool[$urandom_range(0, 5)],
                                   (r == 1) ? $urandom_range(0, SETS - 1) : $urandom_range(0, 3),
                                   $urandom), 1'($urandom_range(0, 1)));
      end
    end
    drain();

    if (n_errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  initial begin
    #1_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/salru_pkg.sv
hw/rtl/salru_lru_update.sv
hw/rtl/set_assoc_lru_cache_tracker.sv
test/tb_top.sv
